// ===== rtl/four_level_page_walker_top_defines.svh =====
// assertion macros for the four-level page walker
`ifndef FOUR_LEVEL_PAGE_WALKER_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_WALKER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PW_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PW_ASSERT(label, clk, rst_n, prop, msg)
`define PW_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/pwalk_pkg.sv =====
// types, codes and helpers shared by the page walker modules
`default_nettype none
package pwalk_pkg;

    localparam logic       ACT_XLATE   = 1'b0;
    localparam logic       ACT_RESP    = 1'b1;
    localparam logic       KIND_READ   = 1'b0;
    localparam logic       KIND_DONE   = 1'b1;
    localparam logic [1:0] PSZ_FAULT   = 2'd0;
    localparam logic [1:0] PSZ_4K      = 2'd1;
    localparam logic [1:0] PSZ_2M      = 2'd2;
    localparam logic [1:0] LVL_PML4    = 2'd0;
    localparam logic [1:0] LVL_PDPT    = 2'd1;
    localparam logic [1:0] LVL_PD      = 2'd2;
    localparam logic [1:0] LVL_PT      = 2'd3;
    localparam logic       CFG_ROOT    = 1'b0;
    localparam logic       CFG_MEMSIZE = 1'b1;
    localparam int         MEM_W       = 53;
    localparam logic [MEM_W-1:0] SZ_4K = 53'h1000;
    localparam logic [MEM_W-1:0] SZ_2M = 53'h200000;
    localparam int         ENTRY_PS    = 7;
    localparam int         ENTRY_P     = 0;

    typedef struct packed {
        logic        action;
        logic [63:0] virtual_address;
        logic [63:0] read_data;
    } walk_in_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] read_address;
        logic [51:0] physical_address;
        logic [1:0]  page_size;
    } walk_out_t;

    typedef struct packed {
        logic        busy;
        logic [1:0]  level;
        logic [47:0] vaddr;
    } walk_state_t;

    // limits derived from memory size when it is written
    typedef struct packed {
        logic [63:0]      root;
        logic [MEM_W-1:0] lim_4k;
        logic             lt_4k;
        logic [MEM_W-1:0] lim_2m;
        logic             lt_2m;
    } walk_cfg_t;

    function automatic logic [8:0] level_index(input logic [47:0] va, input logic [1:0] lvl);
        logic [8:0] idx;
        case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pwalk_cfg.sv =====
// configuration registers with precomputed base limits
`default_nettype none
module pwalk_cfg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [63:0]        cfg_data,
    output pwalk_pkg::walk_cfg_t    cfg
);

    logic [63:0]                root_reg;
    logic [pwalk_pkg::MEM_W-1:0] lim_4k_reg;
    logic                       lt_4k_reg;
    logic [pwalk_pkg::MEM_W-1:0] lim_2m_reg;
    logic                       lt_2m_reg;
    logic [pwalk_pkg::MEM_W-1:0] mem_size;

    assign mem_size = cfg_data[pwalk_pkg::MEM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg   <= '0;
            lim_4k_reg <= '0;
            lt_4k_reg  <= 1'b1;
            lim_2m_reg <= '0;
            lt_2m_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwalk_pkg::CFG_ROOT:
                begin
                    root_reg <= cfg_data;
                end
                pwalk_pkg::CFG_MEMSIZE:
                begin
                    lim_4k_reg <= mem_size - pwalk_pkg::SZ_4K;
                    lt_4k_reg  <= (mem_size[pwalk_pkg::MEM_W-1:12] == '0);
                    lim_2m_reg <= mem_size - pwalk_pkg::SZ_2M;
                    lt_2m_reg  <= (mem_size[pwalk_pkg::MEM_W-1:21] == '0);
                end
                default:
                begin
                    root_reg <= root_reg;
                end
            endcase
        end
    end

    assign cfg.root   = root_reg;
    assign cfg.lim_4k = lim_4k_reg;
    assign cfg.lt_4k  = lt_4k_reg;
    assign cfg.lim_2m = lim_2m_reg;
    assign cfg.lt_2m  = lt_2m_reg;

endmodule
`default_nettype wire

// ===== rtl/pwalk_step.sv =====
// one walk step: decodes a beat against the walk state and forms the result
`default_nettype none
module pwalk_step (
    input  wire pwalk_pkg::walk_in_t    item,
    input  wire pwalk_pkg::walk_state_t st,
    input  wire pwalk_pkg::walk_cfg_t   cfg,
    output logic                        has_result,
    output pwalk_pkg::walk_out_t        result,
    output pwalk_pkg::walk_state_t      st_next
);

    logic [47:0] base;
    logic        base_bad;
    logic [63:0] next_read;
    logic [51:0] large_pa;
    logic        large_bad;
    logic [1:0]  next_lvl;

    assign base     = {item.read_data[47:12], 12'b0};
    assign base_bad = (base[47:12] == '0) || cfg.lt_4k
                      || ({5'b0, base} > cfg.lim_4k);
    assign next_lvl = st.level + 2'd1;
    assign next_read = {16'b0, base}
                       + {52'b0, pwalk_pkg::level_index(st.vaddr, next_lvl), 3'b0};
    assign large_pa  = {item.read_data[51:21], st.vaddr[20:0]};
    assign large_bad = (large_pa == '0) || cfg.lt_2m || ({1'b0, large_pa} > cfg.lim_2m);

    always_comb
    begin
        has_result = 1'b0;
        result     = '0;
        st_next    = st;
        if (item.action == pwalk_pkg::ACT_XLATE)
        begin
            if (!st.busy)
            begin
                st_next.busy   = 1'b1;
                st_next.level  = pwalk_pkg::LVL_PML4;
                st_next.vaddr  = item.virtual_address[47:0];
                has_result     = 1'b1;
                result.kind    = pwalk_pkg::KIND_READ;
                result.read_address = cfg.root + {52'b0,
                    pwalk_pkg::level_index(item.virtual_address[47:0],
                                           pwalk_pkg::LVL_PML4), 3'b0};
            end
        end
        else if (st.busy)
        begin
            has_result  = 1'b1;
            result.kind = pwalk_pkg::KIND_DONE;
            case (st.level)
                pwalk_pkg::LVL_PML4:
                begin
                    if (!base_bad)
                    begin
                        result.kind         = pwalk_pkg::KIND_READ;
                        result.read_address = next_read;
                    end
                end
                pwalk_pkg::LVL_PDPT:
                begin
                    // no 1 GiB pages
                    if (!item.read_data[pwalk_pkg::ENTRY_PS] && !base_bad)
                    begin
                        result.kind         = pwalk_pkg::KIND_READ;
                        result.read_address = next_read;
                    end
                end
                pwalk_pkg::LVL_PD:
                begin
                    if (item.read_data[pwalk_pkg::ENTRY_P])
                    begin
                        if (item.read_data[pwalk_pkg::ENTRY_PS])
                        begin
                            if (!large_bad)
                            begin
                                result.physical_address = large_pa;
                                result.page_size        = pwalk_pkg::PSZ_2M;
                            end
                        end
                        else if (!base_bad)
                        begin
                            result.kind         = pwalk_pkg::KIND_READ;
                            result.read_address = next_read;
                        end
                    end
                end
                default:
                begin
                    if (item.read_data[pwalk_pkg::ENTRY_P] && !base_bad)
                    begin
                        result.physical_address = {4'b0, base[47:12], st.vaddr[11:0]};
                        result.page_size        = pwalk_pkg::PSZ_4K;
                    end
                end
            endcase
            if (result.kind == pwalk_pkg::KIND_READ)
            begin
                st_next.level = next_lvl;
            end
            else
            begin
                st_next.busy  = 1'b0;
                st_next.level = pwalk_pkg::LVL_PML4;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/four_level_page_walker_top.sv =====
// four-level page walker top level: input register, walk state and result register
//
// Takes translate requests and memory response beats on one input channel and
// gives memory read requests and finished translations on the output channel.
// One beat is taken every cycle unless the input side stalls; a beat passes
// through the input register, then the result register. The input side only
// stalls when the result register holds a beat that the output side is
// stalling and the waiting input beat would make a result. Beats that make no
// result (a response while idle, a request during a walk) pass without
// touching the output. Configuration writes are taken whenever cfg_we is high
// and must only come while no walk is in flight.
`default_nettype none
`include "four_level_page_walker_top_defines.svh"
module four_level_page_walker_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [63:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire pwalk_pkg::walk_in_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pwalk_pkg::walk_out_t      out_data
);

    pwalk_pkg::walk_cfg_t   cfg;
    logic                   in_valid_reg;
    pwalk_pkg::walk_in_t    in_item_reg;
    pwalk_pkg::walk_state_t state_reg;
    pwalk_pkg::walk_state_t state_next;
    logic                   out_valid_reg;
    pwalk_pkg::walk_out_t   out_item_reg;
    logic                   has_result;
    pwalk_pkg::walk_out_t   result;
    logic                   advance;
    logic                   in_take;

    pwalk_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwalk_step u_step (
        .item       (in_item_reg),
        .st         (state_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result),
        .st_next    (state_next)
    );

    // the held beat moves on when it needs no output slot or the slot frees up
    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    `PW_NEVER(a_stall_needs_beat, clk, rst_n, in_stall && !in_valid_reg,
        "stall with empty input register")
    `PW_ASSERT(a_done_goes_idle, clk, rst_n,
        advance && has_result && result.kind == pwalk_pkg::KIND_DONE |=> !state_reg.busy,
        "walk still busy after finished beat")
    `PW_ASSERT(a_read_stays_busy, clk, rst_n,
        advance && has_result && result.kind == pwalk_pkg::KIND_READ |=> state_reg.busy,
        "walk idle after read request")
    `PW_ASSERT(a_fault_zero_pa, clk, rst_n,
        out_valid_reg && out_item_reg.kind == pwalk_pkg::KIND_DONE
        && out_item_reg.page_size == pwalk_pkg::PSZ_FAULT
        |-> out_item_reg.physical_address == '0,
        "fault with nonzero address")
    `PW_NEVER(a_size_code, clk, rst_n,
        out_valid_reg && out_item_reg.page_size > pwalk_pkg::PSZ_2M,
        "undefined page size code")

endmodule
`default_nettype wire

// ===== test/page_walk_checker.sv =====
// page walker checker: predicts every result beat from the input beats and compares
module page_walk_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  pwalk_pkg::walk_in_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  pwalk_pkg::walk_out_t out_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   results_due,
    output logic                 walking
);
    import pwalk_pkg::*;

    localparam logic [63:0] TABLE_FIELD  = 64'h0000_FFFF_FFFF_F000;
    localparam logic [63:0] FRAME_2M     = 64'h000F_FFFF_FFE0_0000;
    localparam logic [63:0] OFFSET_2M    = 64'h0000_0000_001F_FFFF;
    localparam logic [63:0] OFFSET_4K    = 64'h0000_0000_0000_0FFF;
    localparam logic [63:0] PAGE_4K      = 64'h1000;
    localparam logic [63:0] PAGE_2M      = 64'h20_0000;

    logic [63:0] root_base;
    logic [63:0] mem_bytes;
    logic [1:0]  level;
    logic [47:0] saved_va;
    walk_out_t   pending_results[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] page walk mismatch, %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [63:0] entry_address(input logic [63:0] table_base,
                                                  input logic [1:0] lvl);
        int unsigned shift;
        logic [8:0]  idx;
        shift = 39 - 9 * lvl;
        idx = 9'({16'd0, saved_va} >> shift);
        return table_base + {52'd0, idx, 3'd0};
    endfunction

    function automatic bit table_out_of_range(input logic [63:0] base);
        return base == '0 || mem_bytes < PAGE_4K || base > mem_bytes - PAGE_4K;
    endfunction

    // advances the walk by one beat; returns whether the beat makes a result
    function automatic bit next_walk_result(input walk_in_t beat, output walk_out_t res);
        logic [63:0] entry;
        logic [63:0] next_base;
        logic [63:0] pa;
        logic [1:0]  psize;
        bit          bad_base;
        bit          done;
        res = '0;
        if (beat.action == ACT_XLATE) begin
            if (walking)
                return 1'b0;
            saved_va = beat.virtual_address[47:0];
            walking = 1'b1;
            level = LVL_PML4;
            res.kind = KIND_READ;
            res.read_address = entry_address(root_base, LVL_PML4);
            return 1'b1;
        end
        if (!walking)
            return 1'b0;
        entry = beat.read_data;
        next_base = entry & TABLE_FIELD;
        bad_base = table_out_of_range(next_base);
        pa = '0;
        psize = PSZ_FAULT;
        done = 1'b1;
        case (level)
            LVL_PML4:
                done = bad_base;
            LVL_PDPT:
                // a 1 GiB page is not supported
                done = entry[ENTRY_PS] || bad_base;
            LVL_PD:
                if (entry[ENTRY_P]) begin
                    if (entry[ENTRY_PS]) begin
                        pa = (entry & FRAME_2M) | ({16'd0, saved_va} & OFFSET_2M);
                        if (!(pa == '0 || mem_bytes < PAGE_2M || pa > mem_bytes - PAGE_2M))
                            psize = PSZ_2M;
                    end else begin
                        done = bad_base;
                    end
                end
            default:
                if (entry[ENTRY_P] && !bad_base) begin
                    pa = next_base | ({16'd0, saved_va} & OFFSET_4K);
                    psize = PSZ_4K;
                end
        endcase
        if (done) begin
            walking = 1'b0;
            level = LVL_PML4;
            res.kind = KIND_DONE;
            res.physical_address = (psize != PSZ_FAULT) ? pa[51:0] : '0;
            res.page_size = psize;
        end else begin
            level = level + 2'd1;
            res.kind = KIND_READ;
            res.read_address = entry_address(next_base, level);
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch_beats
        walk_out_t want;
        walk_out_t predicted;
        if (!rst_n) begin
            root_base = '0;
            mem_bytes = '0;
            walking = 1'b0;
            level = LVL_PML4;
            saved_va = '0;
            pending_results.delete();
            mismatches = 0;
            outstanding = 0;
            results_due = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with none expected", out_data.read_address, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_data.kind != want.kind)
                        report_mismatch("kind", 64'(out_data.kind), 64'(want.kind));
                    if (out_data.read_address != want.read_address)
                        report_mismatch("read_address", out_data.read_address,
                                        want.read_address);
                    if (out_data.physical_address != want.physical_address)
                        report_mismatch("physical_address", 64'(out_data.physical_address),
                                        64'(want.physical_address));
                    if (out_data.page_size != want.page_size)
                        report_mismatch("page_size", 64'(out_data.page_size),
                                        64'(want.page_size));
                end
            end
            if (in_valid && !in_stall && next_walk_result(in_data, predicted)) begin
                pending_results.push_back(predicted);
                results_due++;
            end
            if (cfg_we) begin
                if (cfg_index == CFG_ROOT)
                    root_base = cfg_data;
                else
                    mem_bytes = {11'd0, cfg_data[52:0]};
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// page walker test top: clock, reset, configuration, beat stimulus and verdict
module testbench;
    import pwalk_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          IDLE_PERCENT = 22;
    localparam logic [63:0] TABLE_FIELD  = 64'h0000_FFFF_FFFF_F000;
    localparam logic [63:0] FRAME_2M     = 64'h000F_FFFF_FFE0_0000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    walk_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    walk_out_t   out_data;

    int          mismatches;
    int          outstanding;
    int          results_due;
    logic        walking;

    logic [63:0] mem_limit = '0;
    bit          steady = 1'b0;
    bit          hold_armed = 1'b0;
    bit          hold_taken = 1'b0;
    int          cycles = 0;
    int          goal;

    four_level_page_walker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    page_walk_checker watcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .results_due (results_due),
        .walking     (walking)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stall, plus one long hold-off to fill the block
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input walk_in_t beat);
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_request(input logic [63:0] va);
        walk_in_t beat;
        beat.action = ACT_XLATE;
        beat.virtual_address = va;
        beat.read_data = rand64();
        send_beat(beat);
    endtask

    task automatic send_response(input logic [63:0] entry);
        walk_in_t beat;
        beat.action = ACT_RESP;
        beat.virtual_address = rand64();
        beat.read_data = entry;
        send_beat(beat);
    endtask

    // waits out every expected result; an open walk is closed with an all-zero entry
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        if (walking)
        begin
            send_response('0);
            in_valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [63:0] root, input logic [63:0] mem);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROOT;
        cfg_data  <= root;
        @(posedge clk);
        // bits above the memory size field are don't-care
        cfg_index <= CFG_MEMSIZE;
        cfg_data  <= {11'($urandom), mem[52:0]};
        @(posedge clk);
        cfg_we <= 1'b0;
        mem_limit = {11'd0, mem[52:0]};
    endtask

    // mostly in range, now and then zero or on either side of the top edge
    function automatic logic [63:0] table_base();
        logic [63:0] top_ok;
        int          pick;
        pick = $urandom_range(31);
        if (mem_limit < 64'h2000)
            return 64'($urandom_range(1, 8)) << 12;
        top_ok = mem_limit - 64'h1000;
        if (top_ok > TABLE_FIELD)
            top_ok = TABLE_FIELD;
        if (pick == 0)
            return '0;
        if (pick == 1)
            return top_ok;
        if (pick == 2)
            return (top_ok + 64'h1000) & TABLE_FIELD;
        return ((rand64() % (top_ok >> 12)) + 1) << 12;
    endfunction

    function automatic logic [63:0] large_entry();
        logic [63:0] top_ok;
        logic [63:0] frame;
        logic [63:0] entry;
        if (mem_limit < 64'h40_0000 || $urandom_range(15) == 0)
        begin
            frame = rand64();
        end
        else
        begin
            top_ok = mem_limit - 64'h20_0000;
            frame = ((rand64() % (top_ok >> 21)) + 1) << 21;
        end
        entry = (rand64() & ~FRAME_2M) | (frame & FRAME_2M);
        entry[ENTRY_PS] = 1'b1;
        entry[ENTRY_P] = 1'b1;
        return entry;
    endfunction

    task automatic walk_sequence();
        logic [63:0] entry;
        int          depth;
        bit          big_page;
        // a short sequence leaves the walk open so the next request is dropped
        depth = ($urandom_range(9) == 0) ? $urandom_range(3) : 4;
        big_page = 1'b0;
        send_request(rand64());
        for (int step = 0; step < depth && !big_page; step++)
        begin
            entry = (rand64() & ~TABLE_FIELD) | (table_base() & TABLE_FIELD);
            case (2'(step))
                LVL_PDPT:
                    entry[ENTRY_PS] = ($urandom_range(9) == 0);
                LVL_PD:
                    if ($urandom_range(2) == 0)
                    begin
                        entry = large_entry();
                        big_page = 1'b1;
                    end
                    else
                    begin
                        entry[ENTRY_PS] = 1'b0;
                        entry[ENTRY_P] = ($urandom_range(11) != 0);
                    end
                LVL_PT:
                    entry[ENTRY_P] = ($urandom_range(11) != 0);
                default: ;
            endcase
            send_response(entry);
        end
    endtask

    task automatic run_random(input int target);
        int pick;
        while (results_due < target)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                walk_sequence();
            else if (pick < 90)
                send_response(rand64());
            else
                send_request(rand64());
        end
        quiesce();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ROOT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // root near the top so the first entry address wraps
        write_config(64'hFFFF_FFFF_FFFF_FFF8, 64'h100_0000);
        send_response(64'hFFFF_FFFF_FFFF_FFFF);
        send_request(64'hFFFF_FFFF_FFFF_FFFF);
        send_request('0);
        send_response(64'hFFF0_0000_0000_2FFE);
        send_response(64'h0000_0000_0000_3080);
        send_request(64'h0000_1234_5678_9ABC);
        send_response(64'h0000_0000_00FF_F000);
        send_response(64'h0000_0000_0000_2000);
        send_response(64'h0000_0000_0060_0081);
        send_request(64'hFFFF_8000_0000_1FFF);
        send_response(64'h0000_0000_0000_1000);
        send_response(64'h0000_0000_0000_2000);
        send_response(64'h0000_0000_0000_3001);
        send_response(64'h0000_0000_0000_5001);
        send_request('0);
        send_response(64'h0000_0000_0000_1000);
        send_response(64'h0000_0000_0000_2000);
        send_response(64'h0000_0000_0000_3000);
        send_request('0);
        send_response(64'h0000_0000_0100_0000);
        send_request('0);
        send_response('0);
        send_request(64'h0000_0000_0000_0000);
        send_response(64'h0000_0000_0000_1000);
        send_response(64'h0000_0000_0000_2000);
        send_response(64'h0000_0000_0000_0081);
        quiesce();

        goal = results_due;
        write_config(rand64(), 64'h10_0000_0000_0000);
        goal += 250;
        run_random(goal);

        write_config(64'hFFFF_FFFF_FFFF_FFFF, 64'h100_0000);
        hold_armed = 1'b1;
        goal += 250;
        run_random(goal);

        write_config('0, '0);
        goal += 100;
        run_random(goal);

        write_config(rand64(), 64'hFFF);
        goal += 100;
        run_random(goal);

        steady = 1'b1;
        write_config(rand64(), 64'h20_0000);
        goal += 200;
        run_random(goal);
        steady = 1'b0;

        write_config(rand64(), (rand64() & 64'hFF_FFFF_FFFF) | 64'h2000);
        goal += 300;
        run_random(goal);

        write_config(rand64(), 64'h2000);
        goal += 150;
        run_random(goal);

        write_config(rand64(), (rand64() & 64'h0F_FFFF_FFFF_FFFF) | 64'h40_0000);
        goal += 350;
        run_random(goal);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
